FILE: src/cvg_pkg.sv
// ----------------------------------------------------------------------------
// cvg_pkg
// Shared types, tables and constants of the chord voicing generator.
// ----------------------------------------------------------------------------
package cvg_pkg;

	localparam int NOTE_W  = 7;
	localparam int VEL_W   = 7;
	localparam int BEAT_W  = 5;
	localparam int DEG_W   = 3;
	localparam int MODE_W  = 2;
	localparam int POS_W   = 3;
	localparam int LIM_W   = 4;
	localparam int CNT_W   = 3;
	localparam int ROOT_W  = 8;
	localparam int OFF_W   = 4;
	localparam int VOICE_W = 9;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam int NUM_SCALES = 10;

	localparam logic [VEL_W-1:0]  VEL_PADS  = 7'd100;
	localparam logic [VEL_W-1:0]  VEL_NORM  = 7'd80;
	localparam logic [MODE_W-1:0] MODE_PADS = 2'd2;
	localparam logic [ROOT_W-1:0] ROOT_DFLT = 8'd60;
	localparam logic [3:0]        NUM_KEYS  = 4'd12;
	localparam logic [3:0]        OCT_RST   = 4'd4;
	localparam logic [1:0]        DEN_RST   = 2'd1;
	localparam logic signed [VOICE_W-1:0] OCTAVE    = 9'sd12;
	localparam logic signed [VOICE_W:0]   LEAD_SPAN = 10'sd6;
	localparam logic signed [VOICE_W-1:0] NOTE_MAX  = 9'sd127;

	typedef enum logic [2:0] {
		REG_SCALE   = 3'd0,
		REG_KEY     = 3'd1,
		REG_OCTAVE  = 3'd2,
		REG_DENSITY = 3'd3,
		REG_VLEAD   = 3'd4,
		REG_DROP2   = 3'd5,
		REG_DROP4   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [3:0] scale_select;
		logic [3:0] key_pitch;
		logic [3:0] octave_sel;
		logic [1:0] density;
		logic       voice_lead_en;
		logic       drop2_en;
		logic       drop4_en;
	} cfg_t;

	typedef struct packed {
		logic              emit;
		logic              restart;
		logic              vlead;
		logic              drop2;
		logic              drop4;
		logic [CNT_W-1:0]  n;
		logic [ROOT_W-1:0] root;
		logic [OFF_W-1:0]  off1;
		logic [OFF_W-1:0]  off2;
		logic [OFF_W-1:0]  off3;
		logic [OFF_W-1:0]  off4;
		logic              pads;
		logic [BEAT_W-1:0] start_beat;
		logic [DEG_W-1:0]  degree;
	} cmd_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
		logic [BEAT_W-1:0] start_beat;
		logic [DEG_W-1:0]  degree;
		logic              last;
	} res_t;

	localparam logic [OFF_W-1:0] SCALE_TAB [NUM_SCALES][7] = '{
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11}
	};

	localparam logic [DEG_W-1:0] PROG_TAB [4][8] = '{
		'{3'd0, 3'd4, 3'd5, 3'd3, 3'd0, 3'd3, 3'd4, 3'd0},
		'{3'd0, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd5, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd4, 3'd5, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0}
	};

	localparam logic [LIM_W-1:0] PROG_LEN [4] = '{4'd8, 4'd6, 4'd4, 4'd4};

	function automatic logic [2:0] mod7(input logic [3:0] v);
		logic [3:0] r;
		r = (v >= 4'd7) ? v - 4'd7 : v;
		return r[2:0];
	endfunction

endpackage

FILE: src/cvg_fifo.sv
// ----------------------------------------------------------------------------
// cvg_fifo
// Small synchronous queue with show-ahead read, used between the stages.
// ----------------------------------------------------------------------------
module cvg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/cvg_front.sv
// ----------------------------------------------------------------------------
// cvg_front
// Request classification: range check, progression lookup, chord root and
// scale offsets, note count.
// ----------------------------------------------------------------------------
module cvg_front #(
	parameter int MAX_VOICES = 5
) (
	input  cvg_pkg::cfg_t                   cfg,
	input  logic [cvg_pkg::MODE_W-1:0]      mode,
	input  logic [cvg_pkg::POS_W-1:0]       position,
	input  logic [cvg_pkg::LIM_W-1:0]       chord_limit,
	input  logic                            restart,
	output cvg_pkg::cmd_t                   cmd
);

	logic [3:0]                   sc;
	logic [cvg_pkg::DEG_W-1:0]    deg;
	logic [cvg_pkg::ROOT_W-1:0]   key_root;
	logic [cvg_pkg::CNT_W-1:0]    n_den;
	logic                         in_range;

	always_comb begin
		sc       = (cfg.scale_select < 4'(cvg_pkg::NUM_SCALES)) ? cfg.scale_select : 4'd0;
		deg      = cvg_pkg::PROG_TAB[mode][position];
		in_range = ({1'b0, position} < chord_limit) &&
		           ({1'b0, position} < cvg_pkg::PROG_LEN[mode]);
		if (cfg.key_pitch < cvg_pkg::NUM_KEYS) begin
			key_root = 8'((8'(cfg.octave_sel) + 8'd1) * 8'd12) + 8'(cfg.key_pitch);
		end else begin
			key_root = cvg_pkg::ROOT_DFLT;
		end
		unique case (cfg.density)
			2'd3:    n_den = 3'd5;
			2'd2:    n_den = 3'd4;
			default: n_den = 3'd3;
		endcase

		cmd.emit       = in_range;
		cmd.restart    = restart;
		cmd.vlead      = cfg.voice_lead_en;
		cmd.drop2      = cfg.drop2_en;
		cmd.drop4      = cfg.drop4_en;
		cmd.n          = (n_den > 3'(MAX_VOICES)) ? 3'(MAX_VOICES) : n_den;
		cmd.root       = key_root + 8'(cvg_pkg::SCALE_TAB[sc][deg]);
		cmd.off1       = cvg_pkg::SCALE_TAB[sc][cvg_pkg::mod7(4'(deg) + 4'd2)];
		cmd.off2       = cvg_pkg::SCALE_TAB[sc][cvg_pkg::mod7(4'(deg) + 4'd4)];
		cmd.off3       = cvg_pkg::SCALE_TAB[sc][cvg_pkg::mod7(4'(deg) + 4'd6)];
		cmd.off4       = cvg_pkg::SCALE_TAB[sc][cvg_pkg::mod7(4'(deg) + 4'd1)];
		cmd.pads       = (mode == cvg_pkg::MODE_PADS);
		cmd.start_beat = {position, 2'b00};
		cmd.degree     = deg;
	end

endmodule

FILE: src/cvg_back.sv
// ----------------------------------------------------------------------------
// cvg_back
// Note sequencer: one chord tone per cycle while the result queue has room,
// voice leading against the stored previous voicing, drop voicings, clamp.
// ----------------------------------------------------------------------------
module cvg_back #(
	parameter int MAX_VOICES = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cvg_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	output cvg_pkg::res_t res,
	output logic          res_push,
	input  logic          res_full
);

	localparam int IW = $clog2(MAX_VOICES);

	logic signed [cvg_pkg::VOICE_W-1:0] prev_q [MAX_VOICES];
	logic [cvg_pkg::CNT_W-1:0]          prev_count_q;
	logic [cvg_pkg::CNT_W-1:0]          idx_q;

	logic [cvg_pkg::CNT_W-1:0]          eff_pc;
	logic signed [cvg_pkg::VOICE_W-1:0] root_s;
	logic signed [cvg_pkg::VOICE_W-1:0] base;
	logic signed [cvg_pkg::VOICE_W-1:0] led;
	logic signed [cvg_pkg::VOICE_W-1:0] voice;
	logic signed [cvg_pkg::VOICE_W:0]   diff;
	logic signed [cvg_pkg::VOICE_W-1:0] prev_rd;
	logic                               is_last;
	logic                               step;

	always_comb begin
		eff_pc  = cmd.restart ? '0 : prev_count_q;
		root_s  = $signed({1'b0, cmd.root});
		prev_rd = prev_q[idx_q[IW-1:0]];
		unique case (idx_q)
			3'd0:    base = root_s;
			3'd1:    base = root_s + $signed(9'(cmd.off1));
			3'd2:    base = root_s + $signed(9'(cmd.off2));
			3'd3:    base = root_s + cvg_pkg::OCTAVE + $signed(9'(cmd.off3));
			3'd4:    base = root_s + cvg_pkg::OCTAVE + $signed(9'(cmd.off4));
			default: base = root_s;
		endcase
		diff = {base[cvg_pkg::VOICE_W-1], base} - {prev_rd[cvg_pkg::VOICE_W-1], prev_rd};
		led  = base;
		if (cmd.vlead && (idx_q < eff_pc)) begin
			if (diff > cvg_pkg::LEAD_SPAN) begin
				led = base - cvg_pkg::OCTAVE;
			end else if (diff < -cvg_pkg::LEAD_SPAN) begin
				led = base + cvg_pkg::OCTAVE;
			end
		end
		voice = led;
		if (cmd.n >= 3'd4) begin
			if (cmd.drop2 && (idx_q == cmd.n - 3'd2)) begin
				voice = voice - cvg_pkg::OCTAVE;
			end
			if (cmd.drop4 && (idx_q == cmd.n - 3'd4)) begin
				voice = voice - cvg_pkg::OCTAVE;
			end
		end
		is_last = (idx_q == cmd.n - 3'd1);

		if (voice < 0) begin
			res.note = '0;
		end else if (voice > cvg_pkg::NOTE_MAX) begin
			res.note = cvg_pkg::NOTE_MAX[cvg_pkg::NOTE_W-1:0];
		end else begin
			res.note = voice[cvg_pkg::NOTE_W-1:0];
		end
		res.velocity   = cmd.pads ? cvg_pkg::VEL_PADS : cvg_pkg::VEL_NORM;
		res.start_beat = cmd.start_beat;
		res.degree     = cmd.degree;
		res.last       = is_last;

		step     = cmd_valid && (!cmd.emit || !res_full);
		res_push = cmd_valid && cmd.emit && !res_full;
		cmd_pop  = step && (!cmd.emit || is_last);
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			prev_q[idx_q[IW-1:0]] <= voice;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			idx_q        <= '0;
		end else if (step) begin
			if (!cmd.emit) begin
				prev_count_q <= eff_pc;
			end else if (is_last) begin
				prev_count_q <= cmd.n;
				idx_q        <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

endmodule

FILE: src/chord_voicing_generator_top.sv
// ----------------------------------------------------------------------------
// chord_voicing_generator_top
// Chord request in, one note result per chord tone out; APB register file.
// ----------------------------------------------------------------------------
// The first note of a chord is registered in the request queue and then in
// the result queue before it shows on the result ports. Throughput: the note
// sequencer emits one tone per cycle while the result queue has room; a chord
// has 3 to 5 notes, and a request with no notes yields no result.
// Reset: registers go to their defaults, queues empty, no previous chord.
module chord_voicing_generator_top #(
	parameter int MAX_VOICES = 5,
	parameter int MID_DEPTH  = 2,
	parameter int OUT_DEPTH  = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cvg_pkg::ADDR_W-1:0]    paddr,
	input  logic [cvg_pkg::DATA_W-1:0]    pwdata,
	output logic [cvg_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [cvg_pkg::MODE_W-1:0]    mode,
	input  logic [cvg_pkg::POS_W-1:0]     position,
	input  logic [cvg_pkg::LIM_W-1:0]     chord_limit,
	input  logic                          restart,
	output logic                          empty,
	input  logic                          pop,
	output logic [cvg_pkg::NOTE_W-1:0]    note,
	output logic [cvg_pkg::VEL_W-1:0]     velocity,
	output logic [cvg_pkg::BEAT_W-1:0]    start_beat,
	output logic [cvg_pkg::DEG_W-1:0]     degree,
	output logic                          last
);

	cvg_pkg::cfg_t     cfg_q;
	cvg_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;

	cvg_pkg::cmd_t     front_cmd;
	cvg_pkg::cmd_t     mid_cmd;
	logic              mid_empty;
	logic              mid_pop;
	cvg_pkg::res_t     back_res;
	logic              back_push;
	logic              out_full;
	cvg_pkg::res_t     out_res;

	assign pready  = 1'b1;
	assign reg_idx = cvg_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_select  <= '0;
			cfg_q.key_pitch     <= '0;
			cfg_q.octave_sel    <= cvg_pkg::OCT_RST;
			cfg_q.density       <= cvg_pkg::DEN_RST;
			cfg_q.voice_lead_en <= 1'b0;
			cfg_q.drop2_en      <= 1'b0;
			cfg_q.drop4_en      <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				cvg_pkg::REG_SCALE:   cfg_q.scale_select  <= pwdata[3:0];
				cvg_pkg::REG_KEY:     cfg_q.key_pitch     <= pwdata[3:0];
				cvg_pkg::REG_OCTAVE:  cfg_q.octave_sel    <= pwdata[3:0];
				cvg_pkg::REG_DENSITY: cfg_q.density       <= pwdata[1:0];
				cvg_pkg::REG_VLEAD:   cfg_q.voice_lead_en <= pwdata[0];
				cvg_pkg::REG_DROP2:   cfg_q.drop2_en      <= pwdata[0];
				cvg_pkg::REG_DROP4:   cfg_q.drop4_en      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			cvg_pkg::REG_SCALE:   prdata = 32'(cfg_q.scale_select);
			cvg_pkg::REG_KEY:     prdata = 32'(cfg_q.key_pitch);
			cvg_pkg::REG_OCTAVE:  prdata = 32'(cfg_q.octave_sel);
			cvg_pkg::REG_DENSITY: prdata = 32'(cfg_q.density);
			cvg_pkg::REG_VLEAD:   prdata = 32'(cfg_q.voice_lead_en);
			cvg_pkg::REG_DROP2:   prdata = 32'(cfg_q.drop2_en);
			cvg_pkg::REG_DROP4:   prdata = 32'(cfg_q.drop4_en);
			default:              prdata = '0;
		endcase
	end

	cvg_front #(
		.MAX_VOICES (MAX_VOICES)
	) u_front (
		.cfg         (cfg_q),
		.mode        (mode),
		.position    (position),
		.chord_limit (chord_limit),
		.restart     (restart),
		.cmd         (front_cmd)
	);

	cvg_fifo #(
		.WIDTH ($bits(cvg_pkg::cmd_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_cmd),
		.empty  (mid_empty)
	);

	cvg_back #(
		.MAX_VOICES (MAX_VOICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (mid_cmd),
		.cmd_valid (!mid_empty),
		.cmd_pop   (mid_pop),
		.res       (back_res),
		.res_push  (back_push),
		.res_full  (out_full)
	);

	cvg_fifo #(
		.WIDTH ($bits(cvg_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_push),
		.wdata  (back_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign note       = out_res.note;
	assign velocity   = out_res.velocity;
	assign start_beat = out_res.start_beat;
	assign degree     = out_res.degree;
	assign last       = out_res.last;

	a_mid_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("request popped from empty queue");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		back_push |-> !out_full)
		else $error("note pushed into full result queue");

	a_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (velocity == cvg_pkg::VEL_PADS || velocity == cvg_pkg::VEL_NORM))
		else $error("bad velocity on result");

	a_density_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx == cvg_pkg::REG_DENSITY) |=> cfg_q.density == $past(pwdata[1:0]))
		else $error("density register write lost");

endmodule

FILE: tb/tb_chord_voicing_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chord_voicing_generator_top
// Sends chord requests; checks every note result, field by field, against a
// behavioral voicing model in the bench or the notes of a typed directed row.
// Directed rows come first, then random progressions, random register setups.
// ----------------------------------------------------------------------------
module tb_chord_voicing_generator_top;

	localparam logic [1:0] MODE_ACC  = 2'd0;
	localparam logic [1:0] MODE_LEAD = 2'd1;
	localparam logic [1:0] MODE_PADS = 2'd2;
	localparam logic [1:0] MODE_DFLT = 2'd3;

	localparam int SCALES [10][7] = '{
		'{0, 2, 4, 5, 7, 9, 11},
		'{0, 2, 3, 5, 7, 8, 10},
		'{0, 2, 3, 5, 7, 9, 10},
		'{0, 1, 3, 5, 7, 8, 10},
		'{0, 2, 4, 6, 7, 9, 11},
		'{0, 2, 4, 5, 7, 9, 10},
		'{0, 2, 3, 5, 7, 8, 10},
		'{0, 1, 3, 5, 6, 8, 10},
		'{0, 2, 3, 5, 7, 8, 11},
		'{0, 2, 3, 5, 7, 9, 11}
	};

	localparam int PROGRESSIONS [4][8] = '{
		'{0, 4, 5, 3, 0, 3, 4, 0},
		'{0, 2, 5, 1, 4, 0, 0, 0},
		'{0, 5, 3, 4, 0, 0, 0, 0},
		'{0, 4, 5, 3, 0, 0, 0, 0}
	};

	localparam int CHORDS_IN [4] = '{8, 6, 4, 4};

	typedef struct packed {
		logic [2:0]      cfg_sel;
		logic [1:0]      mode;
		logic [2:0]      pos;
		logic [3:0]      lim;
		logic            rst;
		logic            typed;
		logic [2:0]      cnt;
		logic [2:0]      deg;
		logic [0:4][6:0] tones;
	} chord_req_t;

	localparam logic [0:4][6:0] NO_TONES = '0;
	localparam logic [0:4][6:0] C_TRIAD  = {7'd60, 7'd64, 7'd67, 7'd0, 7'd0};
	localparam logic [0:4][6:0] CLIPPED  = {5{7'd127}};

	// scale, key, octave, density, voice lead, drop-2, drop-4
	localparam cvg_pkg::cfg_t SETUPS [7] = '{
		'{4'd0, 4'd0, 4'd4, 2'd1, 1'b0, 1'b0, 1'b0},
		'{4'd9, 4'd11, 4'd15, 2'd3, 1'b0, 1'b0, 1'b0},
		'{4'd15, 4'd15, 4'd0, 2'd0, 1'b0, 1'b0, 1'b0},
		'{4'd3, 4'd0, 4'd0, 2'd2, 1'b1, 1'b1, 1'b1},
		'{4'd7, 4'd5, 4'd8, 2'd3, 1'b1, 1'b1, 1'b0},
		'{4'd8, 4'd12, 4'd9, 2'd3, 1'b1, 1'b0, 1'b1},
		'{4'd0, 4'd0, 4'd4, 2'd1, 1'b1, 1'b1, 1'b1}
	};

	// cfg, mode, position, limit, restart, typed, count, degree, notes
	localparam chord_req_t DIRECTED [25] = '{
		'{0, MODE_DFLT, 0, 1, 0, 1, 3, 0, C_TRIAD},
		'{0, MODE_ACC, 7, 8, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_LEAD, 5, 15, 1, 0, 0, 0, NO_TONES},
		'{0, MODE_PADS, 3, 4, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_PADS, 4, 8, 0, 1, 0, 0, NO_TONES},
		'{0, MODE_DFLT, 2, 2, 0, 1, 0, 0, NO_TONES},
		'{0, MODE_ACC, 0, 0, 1, 1, 0, 0, NO_TONES},
		'{1, MODE_ACC, 0, 8, 1, 1, 5, 0, CLIPPED},
		'{0, MODE_LEAD, 4, 9, 0, 0, 0, 0, NO_TONES},
		'{2, MODE_DFLT, 0, 4, 1, 1, 3, 0, C_TRIAD},
		'{0, MODE_DFLT, 3, 4, 0, 0, 0, 0, NO_TONES},
		'{3, MODE_ACC, 0, 8, 1, 0, 0, 0, NO_TONES},
		'{0, MODE_ACC, 1, 8, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_ACC, 2, 8, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_LEAD, 7, 15, 0, 1, 0, 0, NO_TONES},
		'{0, MODE_ACC, 3, 8, 0, 0, 0, 0, NO_TONES},
		'{4, MODE_LEAD, 0, 6, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_LEAD, 1, 6, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_LEAD, 3, 6, 1, 0, 0, 0, NO_TONES},
		'{5, MODE_PADS, 0, 4, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_PADS, 1, 4, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_PADS, 3, 4, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_DFLT, 3, 4, 0, 0, 0, 0, NO_TONES},
		'{6, MODE_ACC, 6, 8, 0, 0, 0, 0, NO_TONES},
		'{0, MODE_DFLT, 1, 4, 0, 0, 0, 0, NO_TONES}
	};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [cvg_pkg::ADDR_W-1:0]      paddr = '0;
	logic [cvg_pkg::DATA_W-1:0]      pwdata = '0;
	logic [cvg_pkg::DATA_W-1:0]      prdata;
	logic                            pready;
	logic                            push = 1'b0;
	logic                            full;
	logic [cvg_pkg::MODE_W-1:0]      mode = '0;
	logic [cvg_pkg::POS_W-1:0]       position = '0;
	logic [cvg_pkg::LIM_W-1:0]       chord_limit = '0;
	logic                            restart = 1'b0;
	logic                            empty;
	logic                            pop = 1'b0;
	logic [cvg_pkg::NOTE_W-1:0]      note;
	logic [cvg_pkg::VEL_W-1:0]       velocity;
	logic [cvg_pkg::BEAT_W-1:0]      start_beat;
	logic [cvg_pkg::DEG_W-1:0]       degree;
	logic                            last;

	cvg_pkg::cfg_t cfg_model = SETUPS[0];
	int            held_voicing [5];
	int            held_count = 0;
	cvg_pkg::res_t notes_due [$];
	int            mismatches = 0;
	int            sent = 0;
	int            popped = 0;
	bit            hold_off_req = 1'b0;

	chord_voicing_generator_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.position    (position),
		.chord_limit (chord_limit),
		.restart     (restart),
		.empty       (empty),
		.pop         (pop),
		.note        (note),
		.velocity    (velocity),
		.start_beat  (start_beat),
		.degree      (degree),
		.last        (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int voice_chord(input logic [1:0] m, input logic [2:0] p,
			input logic [3:0] lim, input logic rs);
		int tones [5];
		int base, n, dg, sc, diff, v, i;
		cvg_pkg::res_t r;
		if (rs) begin
			held_count = 0;
		end
		if (p >= lim || int'(p) >= CHORDS_IN[m]) begin
			return 0;
		end
		sc = (cfg_model.scale_select < 10) ? int'(cfg_model.scale_select) : 0;
		dg = PROGRESSIONS[m][p];
		if (cfg_model.key_pitch < 12) begin
			base = (int'(cfg_model.octave_sel) + 1) * 12 + int'(cfg_model.key_pitch);
		end else begin
			base = 60;
		end
		base += SCALES[sc][dg];
		tones[0] = base;
		tones[1] = base + SCALES[sc][(dg + 2) % 7];
		tones[2] = base + SCALES[sc][(dg + 4) % 7];
		tones[3] = base + 12 + SCALES[sc][(dg + 6) % 7];
		tones[4] = base + 12 + SCALES[sc][(dg + 1) % 7];
		n = (cfg_model.density == 3) ? 5 : (cfg_model.density == 2) ? 4 : 3;
		if (cfg_model.voice_lead_en && held_count > 0) begin
			for (i = 0; i < n && i < held_count; i++) begin
				diff = tones[i] - held_voicing[i];
				if (diff > 6) begin
					tones[i] -= 12;
				end else if (diff < -6) begin
					tones[i] += 12;
				end
			end
		end
		if (n >= 4) begin
			if (cfg_model.drop2_en) begin
				tones[n-2] -= 12;
			end
			if (cfg_model.drop4_en) begin
				tones[n-4] -= 12;
			end
		end
		for (i = 0; i < n; i++) begin
			held_voicing[i] = tones[i];
			v = (tones[i] < 0) ? 0 : (tones[i] > 127) ? 127 : tones[i];
			r.note       = 7'(v);
			r.velocity   = (m == MODE_PADS) ? 7'd100 : 7'd80;
			r.start_beat = {p, 2'b00};
			r.degree     = 3'(dg);
			r.last       = (i == n - 1);
			notes_due = {notes_due, r};
		end
		held_count = n;
		return n;
	endfunction

	task automatic apb_xfer(input logic wr, input cvg_pkg::reg_idx_t idx,
			input logic [31:0] wd, output logic [31:0] rd);
		bit done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			rd   = prdata;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_cfg(input cvg_pkg::cfg_t c);
		logic [31:0]        vals [7];
		logic [31:0]        rd;
		cvg_pkg::reg_idx_t  idx;
		vals[cvg_pkg::REG_SCALE]   = 32'(c.scale_select);
		vals[cvg_pkg::REG_KEY]     = 32'(c.key_pitch);
		vals[cvg_pkg::REG_OCTAVE]  = 32'(c.octave_sel);
		vals[cvg_pkg::REG_DENSITY] = 32'(c.density);
		vals[cvg_pkg::REG_VLEAD]   = 32'(c.voice_lead_en);
		vals[cvg_pkg::REG_DROP2]   = 32'(c.drop2_en);
		vals[cvg_pkg::REG_DROP4]   = 32'(c.drop4_en);
		idx = idx.first();
		repeat (7) begin
			apb_xfer(1'b1, idx, vals[idx], rd);
			idx = idx.next();
		end
		idx = idx.first();
		repeat (7) begin
			apb_xfer(1'b0, idx, '0, rd);
			if (rd !== vals[idx]) begin
				$error("prdata %s: expected %0h, got %0h", idx.name(), vals[idx], rd);
				mismatches++;
			end
			idx = idx.next();
		end
		cfg_model = c;
	endtask

	task automatic drain_notes(input int tail);
		while (notes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (tail) @(posedge clk);
	endtask

	task automatic send_chord(input logic [1:0] m, input logic [2:0] p,
			input logic [3:0] l, input logic r, output int n);
		int gap;
		bit taken;
		gap = ((sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		mode        <= m;
		position    <= p;
		chord_limit <= l;
		restart     <= r;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		sent++;
		n = voice_chord(m, p, l, r);
	endtask

	initial begin : request_side
		chord_req_t    row;
		cvg_pkg::cfg_t c;
		cvg_pkg::res_t r;
		int            n, i, phase, sounded, seq_pos, seq_lim;
		logic [1:0]    seq_mode, m;
		logic [2:0]    p;
		logic [3:0]    l;
		logic          rs;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k]) begin
			row = DIRECTED[k];
			if (row.cfg_sel != 0) begin
				push <= 1'b0;
				drain_notes(4);
				load_cfg(SETUPS[row.cfg_sel]);
			end
			send_chord(row.mode, row.pos, row.lim, row.rst, n);
			if (row.typed) begin
				repeat (n) void'(notes_due.pop_back());
				for (i = 0; i < row.cnt; i++) begin
					r.note       = row.tones[i];
					r.velocity   = (row.mode == MODE_PADS) ? 7'd100 : 7'd80;
					r.start_beat = {row.pos, 2'b00};
					r.degree     = row.deg;
					r.last       = (i == row.cnt - 1);
					notes_due = {notes_due, r};
				end
			end
		end

		seq_pos  = 0;
		seq_lim  = 0;
		seq_mode = MODE_ACC;
		for (phase = 0; phase < 6; phase++) begin
			push <= 1'b0;
			drain_notes(4);
			c.scale_select  = 4'($urandom_range(0, 15));
			c.key_pitch     = 4'($urandom_range(0, 15));
			c.octave_sel    = 4'($urandom_range(0, 15));
			c.density       = 2'($urandom_range(0, 3));
			c.voice_lead_en = 1'($urandom_range(0, 1));
			c.drop2_en      = 1'($urandom_range(0, 1));
			c.drop4_en      = 1'($urandom_range(0, 1));
			load_cfg(c);
			if (phase == 2) begin
				hold_off_req = 1'b1;
			end
			sounded = 0;
			while (sounded < 37) begin
				if (seq_pos >= seq_lim) begin
					seq_mode = 2'($urandom_range(0, 3));
					seq_lim  = $urandom_range(1, 8);
					seq_pos  = 0;
				end
				if ($urandom_range(0, 9) < 8) begin
					m  = seq_mode;
					p  = 3'(seq_pos);
					l  = 4'(seq_lim);
					rs = (seq_pos == 0);
					seq_pos++;
				end else begin
					m  = 2'($urandom_range(0, 3));
					p  = 3'($urandom_range(0, 7));
					l  = 4'($urandom_range(0, 15));
					rs = ($urandom_range(0, 7) == 0);
				end
				send_chord(m, p, l, rs, n);
				if (n > 0) begin
					sounded++;
				end
			end
		end

		push <= 1'b0;
		drain_notes(20);
		if (mismatches == 0) begin
			$display("tb_chord_voicing_generator_top: PASS");
		end else begin
			$display("tb_chord_voicing_generator_top: FAIL");
		end
		$finish;
	end

	initial begin : result_side
		int            stall;
		bit            taken;
		cvg_pkg::res_t got, want;

		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				stall = 300;
				hold_off_req = 1'b0;
			end else if ((popped / 50) % 3 == 1) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 13);
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(negedge clk);
				taken = !empty;
				got   = {note, velocity, start_beat, degree, last};
				@(posedge clk);
			end while (!taken);
			popped++;
			if (notes_due.size() == 0) begin
				$error("unexpected note result: note %0d", got.note);
				mismatches++;
			end else begin
				want = notes_due.pop_front();
				if (got.note !== want.note) begin
					$error("note: expected %0d, got %0d", want.note, got.note);
					mismatches++;
				end
				if (got.velocity !== want.velocity) begin
					$error("velocity: expected %0d, got %0d", want.velocity, got.velocity);
					mismatches++;
				end
				if (got.start_beat !== want.start_beat) begin
					$error("start_beat: expected %0d, got %0d", want.start_beat,
						got.start_beat);
					mismatches++;
				end
				if (got.degree !== want.degree) begin
					$error("degree: expected %0d, got %0d", want.degree, got.degree);
					mismatches++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, got.last);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("tb_chord_voicing_generator_top: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/cvg_pkg.sv
src/cvg_fifo.sv
src/cvg_front.sv
src/cvg_back.sv
src/chord_voicing_generator_top.sv
tb/tb_chord_voicing_generator_top.sv
